// ===== rtl/compass_heading_atan2_unit_macros.svh =====
// Assertion macros used by the checker file of the compass heading unit.
`ifndef COMPASS_HEADING_ATAN2_UNIT_MACROS_SVH
`define COMPASS_HEADING_ATAN2_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CHAU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compass heading check failed");

// Next-cycle implication, ignored while reset is high.
`define CHAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compass heading check failed");

// Next-cycle implication that is also checked during reset.
`define CHAU_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("compass heading check failed");

`endif

// ===== rtl/chau_pkg.sv =====
// ----------------------------------------------------------------------------
// chau_pkg
// Types and constants of the compass heading CORDIC unit.
// ----------------------------------------------------------------------------
package chau_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int TABLE_LEN      = 24;

  // Vector lanes carry the offset-corrected sample with 8 fraction bits.
  localparam int IN_W   = 16;
  localparam int DIFF_W = IN_W + 1;
  localparam int FRAC_W = 8;
  localparam int XW     = 28;
  // Angle accumulator in units of 2^-16 degree.
  localparam int ZW      = 26;
  localparam int ANGLE_W = 22;
  localparam int HW      = 15;
  localparam int ROUND_SHIFT = 10;

  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);
  localparam logic signed [ZW-1:0] HALF_LSB = ZW'(512);
  localparam logic [HW-1:0] HEADING_FULL = HW'(23040);

  // Register indexes of the write port.
  localparam logic REG_X_OFFSET = 1'b0;
  localparam logic REG_Y_OFFSET = 1'b1;

  // round(atan(2^-i) * 180/pi * 65536)
  localparam logic [ANGLE_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

endpackage

// ===== rtl/chau_prerot.sv =====
// ----------------------------------------------------------------------------
// chau_prerot
// Offset removal and half-plane pre-rotation, first register of the chain.
// ----------------------------------------------------------------------------
module chau_prerot (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [chau_pkg::IN_W-1:0]    x_offset,
  input  logic signed [chau_pkg::IN_W-1:0]    y_offset,
  input  logic signed [chau_pkg::IN_W-1:0]    raw_x,
  input  logic signed [chau_pkg::IN_W-1:0]    raw_y,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output chau_pkg::vec_t                      out_data
);

  logic signed [chau_pkg::DIFF_W-1:0] dx;
  logic signed [chau_pkg::DIFF_W-1:0] dy;
  logic signed [chau_pkg::XW-1:0]     xs;
  logic signed [chau_pkg::XW-1:0]     ys;
  chau_pkg::vec_t                     data_next;

  assign dx = {raw_x[chau_pkg::IN_W-1], raw_x} - {x_offset[chau_pkg::IN_W-1], x_offset};
  assign dy = {raw_y[chau_pkg::IN_W-1], raw_y} - {y_offset[chau_pkg::IN_W-1], y_offset};

  assign xs = {{(chau_pkg::XW-chau_pkg::DIFF_W-chau_pkg::FRAC_W){dx[chau_pkg::DIFF_W-1]}},
               dx, {chau_pkg::FRAC_W{1'b0}}};
  assign ys = {{(chau_pkg::XW-chau_pkg::DIFF_W-chau_pkg::FRAC_W){dy[chau_pkg::DIFF_W-1]}},
               dy, {chau_pkg::FRAC_W{1'b0}}};

  // A vector in the left half-plane is turned by 180 degrees first.
  always_comb begin
    data_next.zero = (dx == '0) && (dy == '0);
    if (dx[chau_pkg::DIFF_W-1]) begin
      data_next.x = -xs;
      data_next.y = -ys;
      data_next.z = chau_pkg::DEG180;
    end else begin
      data_next.x = xs;
      data_next.y = ys;
      data_next.z = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/chau_cell.sv =====
// ----------------------------------------------------------------------------
// chau_cell
// One CORDIC vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module chau_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  chau_pkg::vec_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output chau_pkg::vec_t out_data
);

  localparam logic signed [chau_pkg::ZW-1:0] ANGLE =
    $signed({{(chau_pkg::ZW-chau_pkg::ANGLE_W){1'b0}}, chau_pkg::ATAN_TABLE[STAGE]});

  logic signed [chau_pkg::XW-1:0] x;
  logic signed [chau_pkg::XW-1:0] y;
  logic signed [chau_pkg::XW-1:0] x_sh;
  logic signed [chau_pkg::XW-1:0] y_sh;
  chau_pkg::vec_t                 data_next;

  assign x    = in_data.x;
  assign y    = in_data.y;
  assign x_sh = x >>> STAGE;
  assign y_sh = y >>> STAGE;

  // Rotate toward the x axis; an exact zero y counts as positive.
  always_comb begin
    data_next.zero = in_data.zero;
    if (!y[chau_pkg::XW-1]) begin
      data_next.x = x + y_sh;
      data_next.y = y - x_sh;
      data_next.z = in_data.z + ANGLE;
    end else begin
      data_next.x = x - y_sh;
      data_next.y = y + x_sh;
      data_next.z = in_data.z - ANGLE;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/chau_post.sv =====
// ----------------------------------------------------------------------------
// chau_post
// Angle wrap to [0, 360), rounding to 1/64 degree and the output register.
// ----------------------------------------------------------------------------
module chau_post (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  chau_pkg::vec_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [chau_pkg::HW-1:0]     heading,
  output logic                        zero_vector
);

  logic signed [chau_pkg::ZW-1:0] z_wrap;
  logic signed [chau_pkg::ZW-1:0] z_round;
  logic [chau_pkg::HW-1:0]        h_raw;
  logic [chau_pkg::HW-1:0]        heading_next;

  always_comb begin
    z_wrap  = in_data.z[chau_pkg::ZW-1] ? in_data.z + chau_pkg::DEG360 : in_data.z;
    z_round = z_wrap + chau_pkg::HALF_LSB;
    h_raw   = z_round[chau_pkg::ROUND_SHIFT +: chau_pkg::HW];
    if (in_data.zero || (h_raw == chau_pkg::HEADING_FULL)) begin
      heading_next = '0;
    end else begin
      heading_next = h_raw;
    end
  end

  assign in_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      heading     <= heading_next;
      zero_vector <= in_data.zero;
    end
  end

endmodule

// ===== rtl/compass_heading_atan2_unit.sv =====
// Path: an accepted item passes the pre-rotation register, the cell registers and the output register in order.
// Throughput: one item per cycle while out_stall is low; every cell holds one item and passes it on
// whenever the cell after it is empty or moving, so empty slots close up under stall.
// Reset: synchronous, clears all valid bits and both offset registers to 0.
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit
// Clockwise compass heading from a magnetometer sample by a pipelined CORDIC.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit #(
  parameter int ITERATIONS = chau_pkg::ITERATIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic                             wr_index,
  input  logic [chau_pkg::IN_W-1:0]        wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [chau_pkg::IN_W-1:0] raw_x,
  input  logic signed [chau_pkg::IN_W-1:0] raw_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [chau_pkg::HW-1:0]          heading,
  output logic                             zero_vector
);

  logic signed [chau_pkg::IN_W-1:0] x_offset;
  logic signed [chau_pkg::IN_W-1:0] y_offset;

  logic           pre_ready;
  logic           vld   [0:ITERATIONS];
  logic           rdy   [0:ITERATIONS];
  chau_pkg::vec_t vec   [0:ITERATIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      y_offset <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        chau_pkg::REG_X_OFFSET: x_offset <= $signed(wr_data);
        chau_pkg::REG_Y_OFFSET: y_offset <= $signed(wr_data);
        default: ;
      endcase
    end
  end

  assign in_stall = !pre_ready;

  chau_prerot u_prerot (
    .clk       (clk),
    .rst       (rst),
    .x_offset  (x_offset),
    .y_offset  (y_offset),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .in_valid  (in_valid),
    .in_ready  (pre_ready),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (vec[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    chau_cell #(
      .STAGE (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_data   (vec[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (vec[k+1])
    );
  end

  chau_post u_post (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (vld[ITERATIONS]),
    .in_ready    (rdy[ITERATIONS]),
    .in_data     (vec[ITERATIONS]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .heading     (heading),
    .zero_vector (zero_vector)
  );

endmodule

// ===== rtl/chau_checker.sv =====
// ----------------------------------------------------------------------------
// chau_checker
// Port-level checks of the compass heading unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "compass_heading_atan2_unit_macros.svh"

module chau_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [chau_pkg::HW-1:0]          heading,
  input logic                             zero_vector
);

  `CHAU_ASSERT_ALWAYS(a_reset_empties, clk, rst, !out_valid)
  // With the output slot empty the whole chain can move, so input is never held off.
  `CHAU_ASSERT_NOW(a_empty_takes_input, clk, rst, !out_valid, !in_stall)
  `CHAU_ASSERT_NOW(a_heading_range, clk, rst, out_valid, heading < chau_pkg::HEADING_FULL)
  `CHAU_ASSERT_NOW(a_zero_heading, clk, rst, out_valid && zero_vector, heading == '0)
  `CHAU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(heading) && $stable(zero_vector))

endmodule

bind compass_heading_atan2_unit chau_checker u_chau_checker (.*);
